@@ sv/wavelength_to_wavenumber_resampler_unit_defines.svh @@
// Assertion macros for the wavelength to wavenumber resampler
`ifndef WAVELENGTH_TO_WAVENUMBER_RESAMPLER_UNIT_DEFINES_SVH
`define WAVELENGTH_TO_WAVENUMBER_RESAMPLER_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define WWR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define WWR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/wwr_pkg.sv @@
// Shared types and constants of the wavelength to wavenumber resampler
`default_nettype none

package wwr_pkg;

   localparam int LINE_MAX   = 4096;
   localparam int IDX_W      = $clog2(LINE_MAX);
   localparam int LEN_W      = IDX_W + 1;
   localparam int SAMPLE_W   = 16;
   localparam int FRAC_W     = 16;
   localparam int WL_W       = 20;
   localparam int CSR_W      = 20;
   localparam int CSR_ADDR_W = 2;
   localparam int NM_W       = 2 * IDX_W;
   localparam int NUM_W      = NM_W + WL_W;
   localparam int DEN_W      = IDX_W + WL_W;
   localparam int QUOT_W     = IDX_W + FRAC_W;
   localparam int CNT_W      = $clog2(QUOT_W);
   localparam int PROD_W     = 2 * (SAMPLE_W + 1);
   localparam int SUM_W      = PROD_W + 1;
   localparam int HALF       = 1 << (FRAC_W - 1);

   localparam logic [LEN_W-1:0] LEN_MIN    = LEN_W'(3);
   localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(LINE_MAX);
   localparam logic [LEN_W-1:0] LEN_RESET  = LEN_W'(2048);
   localparam logic [WL_W-1:0]  START_RESET = WL_W'(1000);
   localparam logic [WL_W-1:0]  END_RESET   = WL_W'(1100);

   localparam logic [CSR_ADDR_W-1:0] CSR_LINE_LENGTH      = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_START_WAVELENGTH = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_END_WAVELENGTH   = CSR_ADDR_W'(2);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_NM,
      ST_MUL_NUM,
      ST_MUL_ML1,
      ST_MUL_NDIFF,
      ST_DEN,
      ST_DIV,
      ST_RD_A,
      ST_RD_B,
      ST_MUL_INT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic mul_nm;
      logic mul_num;
      logic mul_ml1;
      logic mul_ndiff;
      logic den_load;
      logic div_step;
      logic rd_a;
      logic rd_b;
      logic mul_int;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic pass;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ sv/wwr_ram.sv @@
// Generic single write port RAM with registered read
`default_nettype none

module wwr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/wwr_ctrl.sv @@
// Sequencing state machine of the resampler
`default_nettype none

module wwr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire wwr_pkg::status_type status,
   output wwr_pkg::cmd_type        cmd
);
   import wwr_pkg::*;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               div_last;

   assign div_last = (cnt_ff == CNT_W'(QUOT_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.pass ? ST_OUT : ST_MUL_NM;
            end
         end
         ST_MUL_NM:    state_in = ST_MUL_NUM;
         ST_MUL_NUM:   state_in = ST_MUL_ML1;
         ST_MUL_ML1:   state_in = ST_MUL_NDIFF;
         ST_MUL_NDIFF: state_in = ST_DEN;
         ST_DEN:       state_in = ST_DIV;
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_RD_A;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_RD_A:      state_in = ST_RD_B;
         ST_RD_B:      state_in = ST_MUL_INT;
         ST_MUL_INT:   state_in = ST_OUT;
         ST_OUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd           = '0;
      req_stall     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE:      cmd.accept    = req_valid;
         ST_MUL_NM:    cmd.mul_nm    = 1'b1;
         ST_MUL_NUM:   cmd.mul_num   = 1'b1;
         ST_MUL_ML1:   cmd.mul_ml1   = 1'b1;
         ST_MUL_NDIFF: cmd.mul_ndiff = 1'b1;
         ST_DEN:       cmd.den_load  = 1'b1;
         ST_DIV:       cmd.div_step  = 1'b1;
         ST_RD_A:      cmd.rd_a      = 1'b1;
         ST_RD_B:      cmd.rd_b      = 1'b1;
         ST_MUL_INT:   cmd.mul_int   = 1'b1;
         ST_OUT:       cmd.out_load  = status.out_free;
         default:      cmd           = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ sv/wwr_dpath.sv @@
// Datapath: config registers, line buffer, position divider, interpolator
`default_nettype none

module wwr_dpath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire wwr_pkg::cmd_type                   cmd,
   output wwr_pkg::status_type                     status,
   input  wire logic signed [wwr_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                               csr_write,
   input  wire logic [wwr_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  wire logic [wwr_pkg::CSR_W-1:0]           csr_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [wwr_pkg::SAMPLE_W-1:0]      rsp_out_sample,
   output logic                                    rsp_last_of_line,
   output logic                                    rsp_config_error
);
   import wwr_pkg::*;

   // configuration
   logic [LEN_W-1:0] line_length_ff;
   logic [WL_W-1:0]  start_wl_ff, end_wl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LEN_RESET;
         start_wl_ff    <= START_RESET;
         end_wl_ff      <= END_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LINE_LENGTH:      line_length_ff <= csr_data[LEN_W-1:0];
            CSR_START_WAVELENGTH: start_wl_ff    <= csr_data[WL_W-1:0];
            CSR_END_WAVELENGTH:   end_wl_ff      <= csr_data[WL_W-1:0];
            default:              ;
         endcase
      end
   end

   // request decode
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] len_c, len_m1_c;
   logic [IDX_W-1:0] m_c, n_c;
   logic             last_c, err_c, pass_c;

   always_comb begin
      priority if (line_length_ff < LEN_MIN) begin
         len_c = LEN_MIN;
      end else if (line_length_ff > LEN_MAX) begin
         len_c = LEN_MAX;
      end else begin
         len_c = line_length_ff;
      end
      len_m1_c = len_c - LEN_W'(1);
      m_c      = len_m1_c[IDX_W-1:0];
      // index left over from a longer line starts a new one
      n_c      = ({1'b0, idx_ff} >= len_c) ? '0 : idx_ff;
      last_c   = (n_c == m_c);
      err_c    = (end_wl_ff <= start_wl_ff);
      pass_c   = err_c | (n_c == '0) | last_c;
      idx_in   = last_c ? '0 : n_c + IDX_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.accept) begin
         idx_ff <= idx_in;
      end
   end

   logic [IDX_W-1:0]          n_ff, m_ff;
   logic                      last_ff, err_ff, pass_ff;
   logic signed [SAMPLE_W-1:0] raw_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         n_ff    <= n_c;
         m_ff    <= m_c;
         last_ff <= last_c;
         err_ff  <= err_c;
         pass_ff <= pass_c;
         raw_ff  <= req_sample;
      end
   end

   // position numerator and denominator, one multiply per cycle
   logic [NM_W-1:0]   nm_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]  t_ff, u_ff, den_ff;
   logic [WL_W-1:0]   wl_diff_c;

   assign wl_diff_c = end_wl_ff - start_wl_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_nm) begin
         nm_ff <= NM_W'(n_ff) * NM_W'(m_ff);
      end
      if (cmd.mul_num) begin
         num_ff <= NUM_W'(nm_ff) * NUM_W'(start_wl_ff);
      end
      if (cmd.mul_ml1) begin
         t_ff <= DEN_W'(m_ff) * DEN_W'(end_wl_ff);
      end
      if (cmd.mul_ndiff) begin
         u_ff <= DEN_W'(n_ff) * DEN_W'(wl_diff_c);
      end
   end

   // restoring divider: quotient of num*2^F / den, below n*2^F so QUOT_W bits suffice
   logic [DEN_W-1:0]  rem_ff;
   logic [QUOT_W-1:0] shq_ff;
   logic [DEN_W:0]    trial_c, trial_sub_c;
   logic              qbit_c;

   always_comb begin
      trial_c     = {rem_ff, shq_ff[QUOT_W-1]};
      qbit_c      = (trial_c >= {1'b0, den_ff});
      trial_sub_c = trial_c - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.den_load) begin
         den_ff <= t_ff - u_ff;
         rem_ff <= num_ff[NUM_W-1 -: DEN_W];
         shq_ff <= {num_ff[NUM_W-DEN_W-1:0], FRAC_W'(0)};
      end else if (cmd.div_step) begin
         rem_ff <= qbit_c ? trial_sub_c[DEN_W-1:0] : trial_c[DEN_W-1:0];
         shq_ff <= {shq_ff[QUOT_W-2:0], qbit_c};
      end
   end

   // split position, clamp to L-2, read both neighbours
   logic [IDX_W-1:0]  q_raw_c, q_c, q_ff, qmax_c, rd_addr_c;
   logic [FRAC_W-1:0] f_c, f_ff;
   logic [SAMPLE_W-1:0] rd_data;
   logic signed [SAMPLE_W-1:0] a_ff;

   always_comb begin
      q_raw_c = shq_ff[QUOT_W-1:FRAC_W];
      qmax_c  = m_ff - IDX_W'(1);
      if (q_raw_c > qmax_c) begin
         q_c = qmax_c;
         f_c = '0;
      end else begin
         q_c = q_raw_c;
         f_c = shq_ff[FRAC_W-1:0];
      end
      rd_addr_c = cmd.rd_a ? q_c : q_ff + IDX_W'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_a) begin
         q_ff <= q_c;
         f_ff <= f_c;
      end
      if (cmd.rd_b) begin
         a_ff <= $signed(rd_data);
      end
   end

   wwr_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (LINE_MAX)
   ) u_line_buffer (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (n_c),
      .wr_data (req_sample),
      .rd_addr (rd_addr_c),
      .rd_data (rd_data)
   );

   // interpolation: a*2^F + f*(b-a) + half, floored
   logic signed [SAMPLE_W:0]  diff_c, frac_c;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [SUM_W-1:0]   sum_c;
   logic signed [SAMPLE_W-1:0] interp_c, result_c;

   always_comb begin
      diff_c   = $signed({rd_data[SAMPLE_W-1], rd_data}) - $signed({a_ff[SAMPLE_W-1], a_ff});
      frac_c   = $signed({1'b0, f_ff});
      sum_c    = (SUM_W'(a_ff) <<< FRAC_W) + SUM_W'(prod_ff) + SUM_W'(HALF);
      interp_c = sum_c[FRAC_W +: SAMPLE_W];
      result_c = pass_ff ? raw_ff : interp_c;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_int) begin
         prod_ff <= PROD_W'(diff_c) * PROD_W'(frac_c);
      end
   end

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic                       rsp_last_ff, rsp_err_ff;

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_sample_ff <= result_c;
         rsp_last_ff   <= last_ff;
         rsp_err_ff    <= err_ff;
      end
   end

   assign status.pass      = pass_c;
   assign status.out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_sample   = rsp_sample_ff;
   assign rsp_last_of_line = rsp_last_ff;
   assign rsp_config_error = rsp_err_ff;

endmodule

`default_nettype wire

@@ sv/wavelength_to_wavenumber_resampler_unit.sv @@
// Resamples spectral lines from wavelength to wavenumber spacing
// Line ends and bad sweep range pass the sample through to the result load; inner samples
//   take 5 multiply/setup steps, 28 divider steps, 2 reads, a multiply and the result load.
// Requests: no new request is taken until the previous result is loaded; inner samples
//   are held up by the one-bit-per-cycle restoring divider for the source position.
// Reset: sync, active high; clears sample index and result valid, restores register defaults.
`default_nettype none
`include "wavelength_to_wavenumber_resampler_unit_defines.svh"

module wavelength_to_wavenumber_resampler_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [wwr_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [wwr_pkg::SAMPLE_W-1:0]      rsp_out_sample,
   output logic                                    rsp_last_of_line,
   output logic                                    rsp_config_error,
   input  wire logic                               csr_write,
   input  wire logic [wwr_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  wire logic [wwr_pkg::CSR_W-1:0]           csr_data
);
   import wwr_pkg::*;

   cmd_type    cmd;
   status_type status;

   wwr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wwr_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample       (req_sample),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_sample   (rsp_out_sample),
      .rsp_last_of_line (rsp_last_of_line),
      .rsp_config_error (rsp_config_error)
   );

   `WWR_ASSERT_NEXT(a_busy_after_request, clock, reset, req_valid && !req_stall, req_stall, "request not followed by busy")
   `WWR_ASSERT_SAME(a_no_result_overwrite, clock, reset, cmd.out_load, status.out_free, "result loaded over a waiting one")
   `WWR_ASSERT_SAME(a_single_command, clock, reset, 1'b1, $onehot0(cmd), "more than one datapath command")

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for the wavelength to wavenumber resampler unit
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
   import wwr_pkg::*;

   localparam int  SAMPLE_TARGET = 1700;
   localparam int  DRAIN_CYCLES  = 60;
   localparam int  MAX_WAIT      = 11;
   localparam int  WL_TOP        = (1 << WL_W) - 1;
   localparam time RUN_LIMIT     = 20_000_000;

   typedef struct {
      logic signed [SAMPLE_W-1:0] smp;
      logic                       last;
      logic                       err;
   } resample_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_out_sample;
   logic                       rsp_last_of_line;
   logic                       rsp_config_error;
   logic                       csr_write = 1'b0;
   logic [CSR_ADDR_W-1:0]      csr_index = '0;
   logic [CSR_W-1:0]           csr_data = '0;

   wavelength_to_wavenumber_resampler_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_sample   (rsp_out_sample),
      .rsp_last_of_line (rsp_last_of_line),
      .rsp_config_error (rsp_config_error),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // shadow of the block's registers and line store
   logic [LEN_W-1:0]           line_len = LEN_RESET;
   logic [WL_W-1:0]            start_wl = START_RESET;
   logic [WL_W-1:0]            end_wl   = END_RESET;
   logic signed [SAMPLE_W-1:0] line_buf [LINE_MAX];
   int unsigned                next_idx = 0;

   logic signed [SAMPLE_W-1:0] pending_q [$];
   resample_type               expected_q [$];

   int           error_count = 0;
   int           results_seen = 0;
   int           line_ends_seen = 0;
   int           bad_range_seen = 0;
   int           req_gap = 0;
   int           req_quiet = 0;
   int           rsp_hold = 0;
   int           rsp_quiet = 0;
   resample_type got_exp;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // wait drawn from 0..MAX_WAIT, with occasional stretches of none at all
   function automatic int draw_wait(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0)
         quiet = $urandom_range(10, 40);
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // linear interpolation at the exact source position for inner output n
   function automatic logic signed [SAMPLE_W-1:0] interp_at(int unsigned n, int unsigned len);
      longint unsigned lo, hi, m, num, den, q, r, f;
      longint          a, b, v;
      logic [63:0]     vs;
      lo  = start_wl;
      hi  = end_wl;
      m   = len - 1;
      num = longint'(n) * lo * m;
      den = hi * m - longint'(n) * (hi - lo);
      if (den == 0)
         return line_buf[n];
      q = num / den;
      r = num % den;
      f = (r << FRAC_W) / den;
      if (q > len - 2) begin
         q = len - 2;
         f = 0;
      end
      a  = line_buf[q];
      b  = line_buf[q + 1];
      v  = ((longint'(1) << FRAC_W) - longint'(f)) * a + longint'(f) * b
           + (longint'(1) << (FRAC_W - 1));
      vs = v >>> FRAC_W;
      return vs[SAMPLE_W-1:0];
   endfunction

   task automatic resample_step(input logic signed [SAMPLE_W-1:0] smp);
      int unsigned  len, n;
      resample_type e;
      len = line_len;
      if (len < 3)
         len = 3;
      if (len > LINE_MAX)
         len = LINE_MAX;
      n = next_idx;
      if (n >= len)
         n = 0;
      line_buf[n] = smp;
      e.last = (n == len - 1);
      e.err  = (end_wl <= start_wl);
      if (e.err || n == 0 || e.last)
         e.smp = smp;
      else
         e.smp = interp_at(n, len);
      next_idx = e.last ? 0 : n + 1;
      expected_q.push_back(e);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall)
            resample_step(req_sample);
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
               req_sample <= pending_q.pop_front();
               req_valid  <= 1'b1;
               req_gap = draw_wait(req_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               $error("result with nothing expected: out_sample %0d", rsp_out_sample);
               error_count++;
            end else begin
               got_exp = expected_q.pop_front();
               if (rsp_out_sample !== got_exp.smp) begin
                  $error("out_sample: expected %0d, actual %0d", got_exp.smp, rsp_out_sample);
                  error_count++;
               end
               if (rsp_last_of_line !== got_exp.last) begin
                  $error("last_of_line: expected %0b, actual %0b",
                         got_exp.last, rsp_last_of_line);
                  error_count++;
               end
               if (rsp_config_error !== got_exp.err) begin
                  $error("config_error: expected %0b, actual %0b",
                         got_exp.err, rsp_config_error);
                  error_count++;
               end
               if (got_exp.last)
                  line_ends_seen++;
               if (got_exp.err)
                  bad_range_seen++;
            end
            rsp_hold = draw_wait(rsp_quiet);
         end else if (rsp_hold == 0 && !rsp_valid && $urandom_range(0, 7) == 0) begin
            rsp_hold = $urandom_range(1, 5);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_LINE_LENGTH:      line_len = data[LEN_W-1:0];
         CSR_START_WAVELENGTH: start_wl = data[WL_W-1:0];
         CSR_END_WAVELENGTH:   end_wl   = data[WL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_sweep(input int unsigned len, input int unsigned l0, input int unsigned l1);
      write_csr(CSR_LINE_LENGTH, CSR_W'(len));
      write_csr(CSR_START_WAVELENGTH, CSR_W'(l0));
      write_csr(CSR_END_WAVELENGTH, CSR_W'(l1));
   endtask

   task automatic wait_idle();
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] draw_sample();
      case ($urandom_range(0, 15))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return '0;
         3:       return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin
      int          sent;
      int          settings;
      int unsigned len, eff, l0, l1, cnt;
      int          leftover;
      sent = 0;
      settings = 1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // default sweep: full-scale swings through the interpolator
      pending_q = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
      sent += 6;
      wait_idle();

      // shorter line than the current index: restarts at sample 0
      set_sweep(3, 1, WL_TOP);
      pending_q = '{16'sh8000, 16'sh7FFF, 16'sh0001, 16'sh7FFF};
      sent += 4;
      wait_idle();

      // zero length acts as three, equal wavelengths flag the range
      set_sweep(0, 777, 777);
      pending_q = '{16'sh0000, 16'sh8000, 16'sh7FFF};
      sent += 3;
      wait_idle();

      // oversize length clamps to the buffer depth, reversed sweep
      set_sweep(8191, WL_TOP, 1);
      pending_q = '{16'sh1234, 16'shFFFF, 16'sh8000};
      sent += 3;
      wait_idle();

      set_sweep(2, 500, 600);
      pending_q = '{16'sh7FFF, 16'sh8000, 16'sh5555};
      sent += 3;
      wait_idle();

      set_sweep(4, WL_TOP - 1, WL_TOP);
      pending_q = '{16'sh8000, 16'sh7FFF, 16'shAAAA, 16'sh0000};
      sent += 4;
      wait_idle();
      settings += 5;

      while (sent < SAMPLE_TARGET) begin
         case ($urandom_range(0, 19))
            0:       len = $urandom_range(0, 2);
            1:       len = $urandom_range(LINE_MAX + 1, 8191);
            2:       len = LINE_MAX;
            3, 4, 5: len = $urandom_range(41, 400);
            default: len = $urandom_range(3, 40);
         endcase
         eff = (len < 3) ? 3 : (len > LINE_MAX) ? LINE_MAX : len;
         case ($urandom_range(0, 9))
            0: begin
               l0 = $urandom_range(1, WL_TOP);
               l1 = $urandom_range(1, l0);
            end
            1: begin
               l0 = 1;
               l1 = WL_TOP;
            end
            2: begin
               l0 = WL_TOP - 1;
               l1 = WL_TOP;
            end
            3, 4: begin
               l0 = $urandom_range(1, WL_TOP - 1);
               l1 = $urandom_range(l0 + 1, WL_TOP);
            end
            default: begin
               // narrow sweep as a real source would have
               l0 = $urandom_range(1, WL_TOP - 1);
               l1 = l0 + $urandom_range(1, l0 / 4 + 1);
               if (l1 > WL_TOP)
                  l1 = WL_TOP;
            end
         endcase
         if (eff > 200)
            cnt = $urandom_range(20, 80);
         else begin
            cnt = $urandom_range(1, 200 / eff) * eff;
            if ($urandom_range(0, 3) == 0)
               cnt += $urandom_range(1, eff - 1);
         end
         set_sweep(len, l0, l1);
         settings++;
         repeat (cnt)
            pending_q.push_back(draw_sample());
         sent += cnt;
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      leftover = expected_q.size();
      if (leftover != 0)
         $error("%0d expected results never arrived", leftover);
      $display("Run covered %0d samples under %0d sweep settings: %0d results, %0d line ends,",
               sent, settings, results_seen, line_ends_seen);
      $display("  %0d of them flagged for a bad sweep range.", bad_range_seen);
      if (error_count == 0 && leftover == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/wwr_pkg.sv
sv/wwr_ram.sv
sv/wwr_ctrl.sv
sv/wwr_dpath.sv
sv/wavelength_to_wavenumber_resampler_unit.sv
bench/tb_top.sv
